// File: src/ssmt_pkg.sv
// ============================================================================
// ssmt_pkg: shared types and constants for the selection sampling core
// Twister constants, command codes and tempering function.
// ============================================================================
package ssmt_pkg;

    localparam int unsigned MT_N = 624;
    localparam int unsigned MT_M = 397;
    localparam int unsigned IDX_BITS = 10;

    // population and quota counter width
    localparam int COUNT_BITS = 31;

    localparam logic [31:0] MT_MATRIX = 32'h9908b0df;
    localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;

    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_CAND = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] REG_SEED = 2'd0;
    localparam logic [1:0] REG_MODE = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;
    localparam logic [1:0] REG_PCT = 2'd3;

    localparam logic [13:0] PCT_FULL = 14'd10000;

    // 10000 = 16 * 625; floor(z / 625) == (z * PCT_RECIP) >> 40 for z < 2**30
    localparam logic [9:0]  PCT_ODD = 10'd625;
    localparam logic [30:0] PCT_RECIP = 31'd1759218605;

    typedef logic [IDX_BITS-1:0] mt_idx_t;

    function automatic logic [31:0] mt_temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: src/selection_sampling_mt19937_core.sv
// ============================================================================
// selection_sampling_mt19937_core: Algorithm S sampler on an MT19937 source
// Accepts reseed / begin / candidate words; emits one result per candidate.
// ============================================================================
// Reseed: writes each twister word in turn (multiply registered).
// Begin: count mode sets the quota on acceptance; percent mode multiplies, then divides by 10000 via reciprocal.
// Candidate: word read, temper, 31-step modulo, update, then the result;
// the first draw after a reseed and every 624th add a refill of the twister words.
// One word at a time; the next is taken once the result has left.
// Reset (aresetn, sync, low): counters cleared, twister index 624, regs default.
module selection_sampling_mt19937_core (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] population_size
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] selected, [31:1] quota_left
    output logic        m_tuser    // [0] fault
);
    import ssmt_pkg::*;

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam int CW = COUNT_BITS;

    // state codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEED   = 4'd1;
    localparam logic [3:0] ST_SEEDM  = 4'd2;
    localparam logic [3:0] ST_RF0    = 4'd3;
    localparam logic [3:0] ST_RF1    = 4'd4;
    localparam logic [3:0] ST_RF2    = 4'd5;
    localparam logic [3:0] ST_RF3    = 4'd6;
    localparam logic [3:0] ST_RD     = 4'd7;
    localparam logic [3:0] ST_RDW    = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;
    localparam logic [3:0] ST_PMUL   = 4'd11;
    localparam logic [3:0] ST_PQH    = 4'd12;
    localparam logic [3:0] ST_RFW    = 4'd13;
    localparam logic [3:0] ST_PRH    = 4'd14;
    localparam logic [3:0] ST_PQL    = 4'd15;

    // configuration registers
    logic [31:0] seed_reg;
    logic        count_mode_reg;
    logic [30:0] sample_count_reg;
    logic [13:0] pct_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            count_mode_reg <= 1'b1;
            sample_count_reg <= 31'd1;
            pct_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SEED:  seed_reg <= cfg_wdata;
                REG_MODE:  count_mode_reg <= cfg_wdata[0];
                REG_COUNT: sample_count_reg <= cfg_wdata[30:0];
                REG_PCT:   pct_reg <= cfg_wdata[13:0];
                default:   seed_reg <= seed_reg;
            endcase
        end
    end

    logic [3:0]          state_reg;
    mt_idx_t             idx_reg;      // twister index
    mt_idx_t             ptr_reg;      // sweep pointer
    logic [CW-1:0]       remaining_reg;
    logic [CW-1:0]       quota_reg;
    logic [31:0]         prev_reg;     // last word (seed) / word i (refill)
    logic [31:0]         w1_reg;       // word i+1 in refill
    logic [31:0]         prod_reg;
    logic [46:0]         num_reg;      // dividend shift register / percent product
    logic [CW:0]         rem_reg;      // partial remainder
    logic [CW-1:0]       den_reg;
    logic [5:0]          cnt_reg;
    logic [CW-1:0]       n_reg;
    logic [11:0]         qhi_reg;      // percent quota, bits above 20
    logic [9:0]          rhi_reg;      // remainder of the upper chunk by 625
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;
    logic                out_fault_reg;

    logic        ram_we;
    mt_idx_t     ram_addr;
    logic [31:0] ram_wdata;
    logic [31:0] ram_rdata;

    ssmt_ram #(.WIDTH(32), .DEPTH(MT_N)) u_words (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fault_reg;

    wire         acc = s_tvalid && s_tready;
    wire [1:0]   in_cmd = s_tuser;
    wire [30:0]  in_psize = s_tdata[30:0];

    function automatic logic [CW-1:0] sat31(input logic [30:0] v);
        logic [30:0] m;
        m = 31'(CMAX);
        return (v > m) ? CMAX : CW'(v);
    endfunction

    // modulo at idx+M and idx+1 wrap
    function automatic mt_idx_t wrap_add(input mt_idx_t a, input int unsigned b);
        logic [IDX_BITS:0] s;
        s = {1'b0, a} + (IDX_BITS+1)'(b);
        if (s >= (IDX_BITS+1)'(MT_N)) s = s - (IDX_BITS+1)'(MT_N);
        return s[IDX_BITS-1:0];
    endfunction

    // restoring division step (modulo by the remaining count)
    wire [CW:0]  trial = {rem_reg[CW-1:0], num_reg[46]};
    wire         ge = trial >= {1'b0, den_reg};
    wire [CW:0]  rem_step = ge ? trial - {1'b0, den_reg} : trial;

    logic [31:0] tempered;
    assign tempered = mt_temper(ram_rdata);

    // percent quota: x = pct * n, q = floor((x >> 4) / 625), done as a 21-bit
    // upper and a 20-bit lower chunk with a reciprocal multiply each
    logic [13:0] pct_sat;
    logic [44:0] pct_prod;
    logic [51:0] qhi_prod;
    logic [20:0] qhi_back;
    logic [20:0] rhi_full;
    logic [29:0] lo_num;
    logic [60:0] qlo_prod;
    always_comb begin
        pct_sat  = (pct_reg > PCT_FULL) ? PCT_FULL : pct_reg;
        pct_prod = {31'd0, pct_sat} * {14'd0, n_reg};
        qhi_prod = {31'd0, num_reg[44:24]} * {21'd0, PCT_RECIP};
        qhi_back = {9'd0, qhi_reg} * {11'd0, PCT_ODD};
        rhi_full = num_reg[44:24] - qhi_back;
        lo_num   = {rhi_reg, num_reg[23:4]};
        qlo_prod = {31'd0, lo_num} * {30'd0, PCT_RECIP};
    end

    logic [31:0] y_mix;
    logic [31:0] v_new;
    always_comb begin
        y_mix = (prev_reg & 32'h80000000) | (w1_reg & 32'h7fffffff);
        v_new = ram_rdata ^ (y_mix >> 1) ^ (y_mix[0] ? MT_MATRIX : 32'h0);
    end

    always_comb begin
        ram_we = 1'b0;
        ram_addr = ptr_reg;
        ram_wdata = prev_reg;
        unique case (state_reg)
            ST_SEED:  begin ram_we = 1'b1; ram_addr = ptr_reg; ram_wdata = prev_reg; end
            ST_RF0:   ram_addr = ptr_reg;
            ST_RF1:   ram_addr = wrap_add(ptr_reg, 1);
            ST_RF2:   ram_addr = wrap_add(ptr_reg, MT_M);
            ST_RF3:   ram_addr = wrap_add(ptr_reg, MT_M);  // hold word[i+M] on rdata
            ST_RFW:   begin ram_we = 1'b1; ram_addr = ptr_reg; ram_wdata = v_new; end
            ST_RD:    ram_addr = idx_reg;
            default:  ram_addr = ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg <= mt_idx_t'(MT_N);
            remaining_reg <= '0;
            quota_reg <= '0;
            out_valid_reg <= 1'b0;
            ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        priority if (in_cmd == CMD_RESEED) begin
                            prev_reg <= seed_reg;
                            ptr_reg <= '0;
                            state_reg <= ST_SEED;
                        end else if (in_cmd == CMD_BEGIN) begin
                            n_reg <= sat31(in_psize);
                            remaining_reg <= sat31(in_psize);
                            if (count_mode_reg) begin
                                quota_reg <= (sat31(sample_count_reg) > sat31(in_psize))
                                             ? sat31(in_psize) : sat31(sample_count_reg);
                            end else begin
                                state_reg <= ST_PMUL;
                            end
                        end else if (in_cmd == CMD_CAND) begin
                            if (remaining_reg == '0) begin
                                out_data_reg <= {31'(quota_reg), 1'b0};
                                out_fault_reg <= 1'b1;
                                out_valid_reg <= 1'b1;
                            end else if (idx_reg >= mt_idx_t'(MT_N)) begin
                                ptr_reg <= '0;
                                state_reg <= ST_RF0;
                            end else begin
                                state_reg <= ST_RD;
                            end
                        end else begin
                            // spare command code: dropped, no state change
                        end
                    end
                end
                ST_SEED: begin
                    // word ptr written this cycle; compute next
                    prod_reg <= MT_INIT_MUL * (prev_reg ^ (prev_reg >> 30));
                    if (ptr_reg == mt_idx_t'(MT_N - 1)) begin
                        idx_reg <= mt_idx_t'(MT_N);
                        state_reg <= ST_IDLE;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                        state_reg <= ST_SEEDM;
                    end
                end
                ST_SEEDM: begin
                    prev_reg <= prod_reg + 32'(ptr_reg);
                    state_reg <= ST_SEED;
                end
                ST_RF0: state_reg <= ST_RF1;
                ST_RF1: begin prev_reg <= ram_rdata; state_reg <= ST_RF2; end
                ST_RF2: begin w1_reg <= ram_rdata; state_reg <= ST_RF3; end
                ST_RF3: state_reg <= ST_RFW;  // rdata = word[i+M] in ST_RF3 and ST_RFW
                ST_RFW: begin
                    if (ptr_reg == mt_idx_t'(MT_N - 1)) begin
                        idx_reg <= '0;
                        state_reg <= ST_RD;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                        state_reg <= ST_RF0;
                    end
                end
                ST_RD: state_reg <= ST_RDW;
                ST_RDW: begin
                    idx_reg <= idx_reg + 1'b1;
                    num_reg <= {tempered[31:1], 16'd0};
                    rem_reg <= '0;
                    den_reg <= remaining_reg;
                    cnt_reg <= 6'd31;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= rem_step;
                    num_reg <= {num_reg[45:0], ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (rem_reg[CW-1:0] < quota_reg) begin
                        quota_reg <= quota_reg - 1'b1;
                        out_data_reg <= {31'(quota_reg - 1'b1), 1'b1};
                    end else begin
                        out_data_reg <= {31'(quota_reg), 1'b0};
                    end
                    out_fault_reg <= 1'b0;
                    remaining_reg <= remaining_reg - 1'b1;
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_PMUL: begin
                    num_reg <= {2'b00, pct_prod};
                    state_reg <= ST_PQH;
                end
                ST_PQH: begin
                    qhi_reg <= qhi_prod[51:40];
                    state_reg <= ST_PRH;
                end
                ST_PRH: begin
                    rhi_reg <= rhi_full[9:0];
                    state_reg <= ST_PQL;
                end
                ST_PQL: begin
                    // quotient <= n since pct <= 10000, so the upper chunk fits 11 bits
                    quota_reg <= {qhi_reg[10:0], qlo_prod[59:40]};
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result only leaves the idle state through ST_OUT or a fault
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT || $past(state_reg) == ST_IDLE)
        else $error("result raised from unexpected state");
    // a drawn candidate always consumes one from the population
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> remaining_reg == $past(remaining_reg) - 1'b1)
        else $error("remaining not decremented");
    // quota never exceeds remaining outside a begin
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> quota_reg <= remaining_reg)
        else $error("quota above remaining");
endmodule

// File: src/ssmt_ram.sv
// ============================================================================
// ssmt_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
module ssmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: bench/selection_sampling_mt19937_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// selection_sampling_mt19937_core_test: self-checking bench for the sampler
// Drives reseed / begin / candidate words under random idling on both
// streams. A bit-exact MT19937 and Algorithm S predictor supplies the
// expected result for every candidate whose directed row does not pin it.
// ============================================================================
module selection_sampling_mt19937_core_test;
    import ssmt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 2500;   // reseed with margin

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_SEED;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [30:0] population_size
    logic [1:0]  s_tuser = CMD_RESEED;  // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [0] selected, [31:1] quota_left
    logic        m_tuser;          // [0] fault

    selection_sampling_mt19937_core DUT (.*);

    always #5 aclk = ~aclk;

    typedef struct packed {
        logic        sel;
        logic        flt;
        logic [30:0] quota;
    } verdict_t;

    // typed-in answer for a directed row; known == 0 means use the predictor
    typedef struct packed {
        logic     known;
        verdict_t v;
    } pinned_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [30:0] psize;
        logic        known;
        verdict_t    v;
    } row_t;

    // predictor state
    logic [31:0] mt_state [MT_N];
    int unsigned mt_pos = MT_N;
    logic [30:0] left_cnt = '0, owed_cnt = '0;
    logic [31:0] p_seed;
    logic        p_count_mode;
    logic [30:0] p_sample_count;
    logic [13:0] p_pct;

    verdict_t verdict_q [$];
    pinned_t  pinned_q [$];

    int send_idle, recv_idle;
    int n_words = 0, n_results = 0, n_sel = 0, n_fault = 0, n_bad = 0;
    int idle_cycles = 0;
    bit hold_go = 1'b0, hold_seen = 1'b0;
    int hold_left = 0;

    // ---------------- predictor ----------------
    function automatic void twister_load(input logic [31:0] s);
        logic [31:0] p;
        mt_state[0] = s;
        for (int i = 1; i < MT_N; i++) begin
            p = mt_state[i-1];
            mt_state[i] = MT_INIT_MUL * (p ^ (p >> 30)) + i;
        end
        mt_pos = MT_N;
    endfunction

    function automatic logic [31:0] twister_draw();
        logic [31:0] y, v;
        if (mt_pos >= MT_N) begin
            for (int i = 0; i < MT_N; i++) begin
                y = (mt_state[i] & 32'h80000000) | (mt_state[(i+1)%MT_N] & 32'h7fffffff);
                v = mt_state[(i+MT_M)%MT_N] ^ (y >> 1);
                if (y[0]) v = v ^ MT_MATRIX;
                mt_state[i] = v;
            end
            mt_pos = 0;
        end
        y = mt_state[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // returns 1 when the word yields a result
    function automatic bit sample_word(input logic [1:0] cmd, input logic [30:0] psize,
                                       output verdict_t v);
        logic [30:0] n, q;
        logic [13:0] p;
        logic [63:0] prod;
        logic [30:0] r;
        n = psize;
        v = '0;
        case (cmd)
            CMD_RESEED: begin
                twister_load(p_seed);
                return 0;
            end
            CMD_BEGIN: begin
                if (p_count_mode) begin
                    q = p_sample_count;
                end else begin
                    p = (p_pct > PCT_FULL) ? PCT_FULL : p_pct;
                    prod = 64'(p) * 64'(n);
                    q = 31'(prod / 64'(PCT_FULL));
                end
                if (q > n) q = n;
                left_cnt = n;
                owed_cnt = q;
                return 0;
            end
            CMD_CAND: begin
                if (left_cnt == 0) begin
                    v.flt = 1'b1;
                end else begin
                    r = 31'((twister_draw() >> 1) % 32'(left_cnt));
                    if (r < owed_cnt) begin
                        v.sel = 1'b1;
                        owed_cnt--;
                    end
                    left_cnt--;
                end
                v.quota = owed_cnt;
                return 1;
            end
            default: return 0;   // unused command
        endcase
    endfunction

    // ---------------- monitor / scoreboard ----------------
    always @(posedge aclk) begin
        verdict_t v, e;
        pinned_t  pin;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                n_words++;
                pin = pinned_q.pop_front();
                if (sample_word(s_tuser, s_tdata[30:0], v))
                    verdict_q.push_back(pin.known ? pin.v : v);
            end
            if (m_tvalid && m_tready) begin
                n_results++;
                n_sel += m_tdata[0];
                n_fault += m_tuser;
                if (verdict_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("ERROR: result %h with nothing pending", m_tdata);
                end else begin
                    e = verdict_q.pop_front();
                    if (m_tdata[0] !== e.sel || m_tuser !== e.flt ||
                        m_tdata[31:1] !== e.quota) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("ERROR: sel/flt/quota exp %0b/%0b/%0d got %0b/%0b/%0d",
                                     e.sel, e.flt, e.quota,
                                     m_tdata[0], m_tuser, m_tdata[31:1]);
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when hold_go toggles
    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("selection_sampling_mt19937_core verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_word(input logic [1:0] cmd, input logic [30:0] psize,
                             input pinned_t pin);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        pinned_q.push_back(pin);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, psize};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_plain(input logic [1:0] cmd, input logic [30:0] psize);
        send_word(cmd, psize, '0);
    endtask

    // sender stops until every pending result is back, then the core settles
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_SEED:  p_seed = val;
            REG_MODE:  p_count_mode = val[0];
            REG_COUNT: p_sample_count = val[30:0];
            REG_PCT:   p_pct = val[13:0];
            default:   ;
        endcase
    endtask

    function automatic logic [30:0] pick_size();
        int k;
        k = $urandom_range(99);
        if (k < 70) return 31'($urandom_range(1, 24));
        if (k < 80) return 31'($urandom_range(25, 200));
        if (k < 90) return 31'($urandom);        // wide values, every bit toggles
        if (k < 95) return 31'h7fffffff;
        return '0;
    endfunction

    // random phase: mostly complete populations, some noise
    task automatic random_traffic(input int words);
        int sent, k, walk;
        logic [30:0] n;
        sent = 0;
        while (sent < words) begin
            k = $urandom_range(99);
            if (k < 80) begin
                n = pick_size();
                send_plain(CMD_BEGIN, n);
                sent++;
                // walk the population, sometimes past its end, sometimes cut short
                walk = (n > 30) ? int'($urandom_range(1, 30))
                                : int'(n) + int'($urandom_range(0, 2));
                for (int i = 0; i < walk; i++) begin
                    send_plain(CMD_CAND, 31'($urandom));
                    sent++;
                end
            end else if (k < 90) begin
                send_plain(CMD_CAND, 31'($urandom));
                sent++;
            end else if (k < 97) begin
                send_plain(CMD_SPARE, 31'($urandom));   // unused code, ignored
            end else begin
                send_plain(CMD_RESEED, 31'($urandom));
                sent++;
            end
        end
    endtask

    row_t directed [] = '{
        // empty population right after reset: fault, quota 0
        '{CMD_CAND,   31'd7,          1'b1, '{1'b0, 1'b1, 31'd0}},
        '{CMD_SPARE,  31'h7fffffff,   1'b0, '0},
        '{CMD_RESEED, 31'h7fffffff,   1'b0, '0},
        // N = 0: quota clamps to 0, candidate faults
        '{CMD_BEGIN,  31'd0,          1'b0, '0},
        '{CMD_CAND,   31'd0,          1'b1, '{1'b0, 1'b1, 31'd0}},
        // N = 1, quota 1: always selected
        '{CMD_BEGIN,  31'd1,          1'b0, '0},
        '{CMD_CAND,   31'd0,          1'b1, '{1'b1, 1'b0, 31'd0}},
        '{CMD_CAND,   31'd0,          1'b1, '{1'b0, 1'b1, 31'd0}},
        // largest population that fits the input word
        '{CMD_BEGIN,  31'h7fffffff,   1'b0, '0},
        '{CMD_CAND,   31'h2aaaaaaa,   1'b0, '0},
        '{CMD_CAND,   31'h55555555,   1'b0, '0},
        '{CMD_BEGIN,  31'd5,          1'b0, '0},
        '{CMD_CAND,   31'd0,          1'b0, '0},
        '{CMD_CAND,   31'd0,          1'b0, '0},
        '{CMD_CAND,   31'd0,          1'b0, '0},
        '{CMD_CAND,   31'd0,          1'b0, '0},
        '{CMD_CAND,   31'd0,          1'b0, '0},
        '{CMD_CAND,   31'd0,          1'b1, '{1'b0, 1'b1, 31'd0}},
        '{CMD_RESEED, 31'd0,          1'b0, '0}
    };

    // per phase: seed, mode, count, percent
    logic [31:0] phase_cfg [9][4] = '{
        '{32'h00000000,  32'd1, 32'd0,          32'd0},
        '{32'hffffffff,  32'd1, 32'hffffffff,   32'd0},
        '{32'h12345678,  32'd1, 32'd3,          32'd0},
        '{32'h00001571,  32'd0, 32'd1,          32'd10000},
        '{32'h87654321,  32'd0, 32'd1,          32'd0},
        '{32'hdeadbeef,  32'd0, 32'd1,          32'd16383},
        '{32'h0badf00d,  32'd0, 32'd1,          32'd3333},
        '{32'h55555555,  32'd0, 32'd1,          32'd1},
        '{32'haaaaaaaa,  32'd1, 32'd7,          32'd9999}
    };

    initial begin
        pinned_t pin;
        p_seed = 0; p_count_mode = 1'b1; p_sample_count = 31'd1; p_pct = 0;
        send_idle = 16; recv_idle = 56;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table under default registers
        foreach (directed[i]) begin
            pin.known = directed[i].known;
            pin.v = directed[i].v;
            send_word(directed[i].cmd, directed[i].psize, pin);
        end
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin send_idle = 56; recv_idle = 16; end
            if (ph == 6) begin send_idle = 0;  recv_idle = 0;  end
            write_reg(REG_SEED,  phase_cfg[ph][0]);
            write_reg(REG_MODE,  phase_cfg[ph][1]);
            write_reg(REG_COUNT, phase_cfg[ph][2]);
            write_reg(REG_PCT,   phase_cfg[ph][3]);
            cfg_we <= 1'b0;
            send_plain(CMD_RESEED, 31'($urandom));
            if (ph == 4) begin
                // long receiver hold-off while candidates keep coming
                send_plain(CMD_BEGIN, 31'd40);
                hold_go <= ~hold_go;
                for (int i = 0; i < 12; i++) send_plain(CMD_CAND, 31'($urandom));
            end
            random_traffic(60);
            drain();
        end

        $display("Covered %0d input words, %0d results (%0d selected, %0d faults)",
                 n_words, n_results, n_sel, n_fault);
        $display("over 9 register settings, count and percent modes, three idle profiles");
        if (n_bad == 0 && verdict_q.size() == 0)
            $display("selection_sampling_mt19937_core verification clean");
        else
            $display("selection_sampling_mt19937_core verification failed");
        $finish;
    end
endmodule
